[hdl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg
// Types, constants and arithmetic helpers shared by the compositor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CB           = CHANNEL_BITS;
  localparam int FIELD_W      = 8;
  localparam int SAT_W        = (CB > FIELD_W) ? CB : FIELD_W;
  localparam int PROD_W       = 2 * CB;
  localparam int DEN_W        = 2 * CB;
  localparam int NUM_W        = 3 * CB;
  localparam int NCH          = 3;

  localparam logic [CB-1:0]    MAXV      = '1;
  localparam logic [CB-1:0]    HALF_UNIT = {1'b1, {(CB-1){1'b0}}};
  localparam logic [DEN_W-1:0] MAXV_SQ   = {{(CB-1){1'b1}}, {CB{1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    OP_OVER    = 3'd0,
    OP_IN      = 3'd1,
    OP_OUT     = 3'd2,
    OP_ATOP    = 3'd3,
    OP_PLUS    = 3'd4,
    OP_THROUGH = 3'd5
  } op_t;

  typedef logic [CB-1:0]      ch_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic [2:0] opcode;
    field_t     fg_red;
    field_t     fg_green;
    field_t     fg_blue;
    field_t     fg_alpha;
    field_t     bg_red;
    field_t     bg_green;
    field_t     bg_blue;
    field_t     bg_alpha;
  } pdc_in_t;

  typedef struct packed {
    field_t out_red;
    field_t out_green;
    field_t out_blue;
    field_t out_alpha;
  } pdc_out_t;

  typedef struct packed {
    logic [2:0]        op;
    ch_t [NCH-1:0]     fc;
    ch_t [NCH-1:0]     bc;
    ch_t               fa;
    ch_t               ba;
    logic [PROD_W-1:0] aprod;
  } pdc_s1_t;

  typedef struct packed {
    logic [2:0]    op;
    ch_t [NCH-1:0] fc;
    ch_t [NCH-1:0] bc;
    ch_t           fa;
    ch_t           ba;
    ch_t           aw;
  } pdc_s2_t;

  typedef struct packed {
    logic                      thru;
    ch_t [NCH-1:0]             fc;
    logic [NCH-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]          den;
    ch_t                       alpha;
    logic                      zero;
  } pdc_s3_t;

  typedef struct packed {
    logic [NCH-1:0][NUM_W-1:0] rem;
    logic [DEN_W-1:0]          den;
    ch_t [NCH-1:0]             quo;
    ch_t                       alpha;
    logic                      zero;
  } pdc_div_t;

  function automatic ch_t sat_ch(input field_t v);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(v);
    if (ext > SAT_W'(MAXV)) begin
      return MAXV;
    end
    return CB'(ext);
  endfunction

  function automatic ch_t sat_sum(input logic [CB:0] v);
    if (v > (CB+1)'(MAXV)) begin
      return MAXV;
    end
    return CB'(v);
  endfunction

  function automatic ch_t mul_round(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    logic [PROD_W:0] s;
    t = (PROD_W+1)'(p) + (PROD_W+1)'(HALF_UNIT);
    s = t + (t >> CB);
    return CB'(s >> CB);
  endfunction

  function automatic field_t to_field(input ch_t v);
    return FIELD_W'(v);
  endfunction

endpackage

`default_nettype wire

[hdl/pdc_front.sv]
// ----------------------------------------------------------------------------
// pdc_front
// Four-stage front end: alpha product, rounding, channel products, divider
// operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_front import pdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pdc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pdc_div_t      out_data
);

  logic     v1_r, v2_r, v3_r, v4_r;
  logic     rdy1, rdy2, rdy3, rdy4;
  pdc_s1_t  s1_r, s1_nxt;
  pdc_s2_t  s2_r, s2_nxt;
  pdc_s3_t  s3_r, s3_nxt;
  pdc_div_t s4_r, s4_nxt;

  ch_t              mx, my;
  ch_t              ka, kb;
  logic [DEN_W-1:0] inv_ext;
  logic [DEN_W-1:0] thru_base;
  logic [NUM_W-1:0] num_full;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt.op    = in_data.opcode;
    s1_nxt.fc[0] = sat_ch(in_data.fg_red);
    s1_nxt.fc[1] = sat_ch(in_data.fg_green);
    s1_nxt.fc[2] = sat_ch(in_data.fg_blue);
    s1_nxt.bc[0] = sat_ch(in_data.bg_red);
    s1_nxt.bc[1] = sat_ch(in_data.bg_green);
    s1_nxt.bc[2] = sat_ch(in_data.bg_blue);
    s1_nxt.fa    = sat_ch(in_data.fg_alpha);
    s1_nxt.ba    = sat_ch(in_data.bg_alpha);
    mx = (in_data.opcode == OP_OVER) ? MAXV - s1_nxt.fa : s1_nxt.fa;
    my = (in_data.opcode == OP_OUT)  ? MAXV - s1_nxt.ba : s1_nxt.ba;
    s1_nxt.aprod = PROD_W'(mx) * PROD_W'(my);
  end

  always_comb begin
    s2_nxt.op = s1_r.op;
    s2_nxt.fc = s1_r.fc;
    s2_nxt.bc = s1_r.bc;
    s2_nxt.fa = s1_r.fa;
    s2_nxt.ba = s1_r.ba;
    s2_nxt.aw = mul_round(s1_r.aprod);
  end

  always_comb begin
    s3_nxt.thru  = 1'b0;
    s3_nxt.fc    = s2_r.fc;
    s3_nxt.den   = DEN_W'(MAXV);
    s3_nxt.alpha = '0;
    s3_nxt.zero  = 1'b0;
    ka = '0;
    kb = '0;
    case (s2_r.op)
      OP_OVER: begin
        ka           = s2_r.fa;
        kb           = s2_r.aw;
        s3_nxt.den   = DEN_W'(s2_r.fa) + DEN_W'(s2_r.aw);
        s3_nxt.alpha = sat_sum({1'b0, s2_r.fa} + {1'b0, s2_r.aw});
      end
      OP_IN, OP_OUT: begin
        ka           = MAXV;
        s3_nxt.alpha = s2_r.aw;
      end
      OP_ATOP: begin
        ka           = s2_r.fa;
        kb           = MAXV - s2_r.fa;
        s3_nxt.alpha = s2_r.ba;
      end
      OP_PLUS: begin
        ka           = s2_r.fa;
        kb           = s2_r.ba;
        s3_nxt.den   = DEN_W'(s2_r.fa) + DEN_W'(s2_r.ba);
        s3_nxt.alpha = sat_sum({1'b0, s2_r.fa} + {1'b0, s2_r.ba});
      end
      OP_THROUGH: begin
        s3_nxt.thru  = 1'b1;
        s3_nxt.den   = MAXV_SQ;
        s3_nxt.alpha = s2_r.fa;
      end
      default: begin
        s3_nxt.zero  = 1'b1;
      end
    endcase
    if (s3_nxt.den == '0) begin
      s3_nxt.zero = 1'b1;
    end
    inv_ext   = DEN_W'(MAXV - s2_r.ba);
    thru_base = (inv_ext << CB) - inv_ext;
    for (int c = 0; c < NCH; c++) begin
      if (s3_nxt.thru) begin
        s3_nxt.num[c] = NUM_W'(DEN_W'(s2_r.bc[c]) * DEN_W'(s2_r.ba)) + NUM_W'(thru_base);
      end else begin
        s3_nxt.num[c] = NUM_W'(DEN_W'(s2_r.fc[c]) * DEN_W'(ka))
                      + NUM_W'(DEN_W'(s2_r.bc[c]) * DEN_W'(kb));
      end
    end
  end

  always_comb begin
    s4_nxt.den   = s3_r.den;
    s4_nxt.alpha = s3_r.alpha;
    s4_nxt.zero  = s3_r.zero;
    s4_nxt.quo   = '0;
    num_full     = '0;
    for (int c = 0; c < NCH; c++) begin
      num_full      = s3_r.thru ? NUM_W'(s3_r.fc[c]) * s3_r.num[c] : s3_r.num[c];
      s4_nxt.rem[c] = num_full + NUM_W'(s3_r.den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
    if (rdy3 && v2_r)     s3_r <= s3_nxt;
    if (rdy4 && v3_r)     s4_r <= s4_nxt;
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

  a_zero_clears_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && s4_r.zero |-> s4_r.alpha == '0)
    else $error("zero-denominator beat carries nonzero alpha");

endmodule

`default_nettype wire

[hdl/pdc_div.sv]
// ----------------------------------------------------------------------------
// pdc_div
// Restoring divider pipeline: one quotient bit per stage, three channels
// side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_div import pdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pdc_div_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pdc_div_t      out_data
);

  logic     v_r  [CB];
  pdc_div_t st_r [CB];
  pdc_div_t st_nxt [CB];
  pdc_div_t src  [CB];
  logic     src_v [CB];
  logic     rdy  [CB+1];

  assign rdy[CB] = out_ready;

  for (genvar i = 0; i < CB; i++) begin : g_stage
    logic [NUM_W-1:0] shifted;

    if (i == 0) begin : g_first
      assign src[i]   = in_data;
      assign src_v[i] = in_valid;
    end else begin : g_rest
      assign src[i]   = st_r[i-1];
      assign src_v[i] = v_r[i-1];
    end

    assign rdy[i]  = !v_r[i] || rdy[i+1];
    assign shifted = NUM_W'(src[i].den) << (CB - 1 - i);

    always_comb begin
      st_nxt[i] = src[i];
      for (int c = 0; c < NCH; c++) begin
        if (src[i].rem[c] >= shifted) begin
          st_nxt[i].rem[c]            = src[i].rem[c] - shifted;
          st_nxt[i].quo[c][CB-1-i]    = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[CB-1];
  assign out_data  = st_r[CB-1];

  a_first_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && st_r[0].den != '0 |->
      st_r[0].rem[0] < (NUM_W'(st_r[0].den) << (CB - 1)) &&
      st_r[0].rem[1] < (NUM_W'(st_r[0].den) << (CB - 1)) &&
      st_r[0].rem[2] < (NUM_W'(st_r[0].den) << (CB - 1)))
    else $error("quotient overflow in divider front stage");

  a_final_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[CB-1] && st_r[CB-1].den != '0 |->
      st_r[CB-1].rem[0] < NUM_W'(st_r[CB-1].den) &&
      st_r[CB-1].rem[1] < NUM_W'(st_r[CB-1].den) &&
      st_r[CB-1].rem[2] < NUM_W'(st_r[CB-1].den))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[hdl/porter_duff_compositor_core.sv]
// ----------------------------------------------------------------------------
// porter_duff_compositor_core
// Porter-Duff compositor for non-premultiplied RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side does not stall and returns
// one composited pixel per beat, in order. The restoring divider retires one
// quotient bit per pipeline stage; four front stages form the alpha product,
// its rounding, the channel products and the divider operands, and one
// output register closes the path. Every stage holds its own valid bit, so
// bubbles collapse and a stall on the result side backs up stage by stage
// without losing or repeating a beat.
`default_nettype none

module porter_duff_compositor_core import pdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pdc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pdc_out_t      out_data
);

  logic     fr_valid, fr_ready;
  pdc_div_t fr_data;
  logic     dv_valid, dv_ready;
  pdc_div_t dv_data;
  logic     out_valid_r;
  pdc_out_t out_data_r, out_data_nxt;

  pdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  pdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  assign dv_ready = !out_valid_r || out_ready;

  always_comb begin
    out_data_nxt.out_red   = dv_data.zero ? '0 : to_field(dv_data.quo[0]);
    out_data_nxt.out_green = dv_data.zero ? '0 : to_field(dv_data.quo[1]);
    out_data_nxt.out_blue  = dv_data.zero ? '0 : to_field(dv_data.quo[2]);
    out_data_nxt.out_alpha = to_field(dv_data.alpha);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[sim/pdc_blend_checker.sv]
// ----------------------------------------------------------------------------
// pdc_blend_checker
// Watches both channels of the compositor, predicts every pixel and compares.
// ----------------------------------------------------------------------------
// Each accepted input beat is run through a local Porter-Duff model. The
// predicted pixel is queued. Each accepted output beat is compared field by
// field with the oldest queued pixel. The counts are handed to the testbench
// top for the verdict.
`timescale 1ns / 1ps

module pdc_blend_checker import pdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  pdc_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pdc_out_t out_data,
  output int       err_count,
  output int       beats_in,
  output int       beats_out,
  output int       pixels_waiting
);

  localparam longint unsigned UNIT = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam int REPORT_MAX = 10;

  pdc_out_t expected_pixels [$];
  int errs     = 0;
  int n_in     = 0;
  int n_out    = 0;
  int n_wait   = 0;
  int reported = 0;

  assign err_count      = errs;
  assign beats_in       = n_in;
  assign beats_out      = n_out;
  assign pixels_waiting = n_wait;

  function automatic longint unsigned clamp_unit(input longint unsigned v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  function automatic longint unsigned mul_unit(input longint unsigned x,
                                               input longint unsigned y);
    return (x * y + UNIT / 2) / UNIT;
  endfunction

  function automatic longint unsigned div_round(input longint unsigned n,
                                                input longint unsigned d);
    if (d == 0) begin
      return 0;
    end
    return (n + d / 2) / d;
  endfunction

  function automatic pdc_out_t blend_pixel(input pdc_in_t px);
    longint unsigned fc [3];
    longint unsigned bc [3];
    longint unsigned res [4];
    longint unsigned fa;
    longint unsigned ba;
    longint unsigned w;
    longint unsigned den;
    pdc_out_t        r;
    fc[0] = clamp_unit(px.fg_red);
    fc[1] = clamp_unit(px.fg_green);
    fc[2] = clamp_unit(px.fg_blue);
    bc[0] = clamp_unit(px.bg_red);
    bc[1] = clamp_unit(px.bg_green);
    bc[2] = clamp_unit(px.bg_blue);
    fa    = clamp_unit(px.fg_alpha);
    ba    = clamp_unit(px.bg_alpha);
    for (int i = 0; i < 4; i++) begin
      res[i] = 0;
    end
    case (px.opcode)
      OP_OVER: begin
        w   = mul_unit(UNIT - fa, ba);
        den = fa + w;
        for (int i = 0; i < 3; i++) begin
          res[i] = div_round(fc[i] * fa + bc[i] * w, den);
        end
        res[3] = den;
      end
      OP_IN: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = fc[i];
        end
        res[3] = mul_unit(fa, ba);
      end
      OP_OUT: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = fc[i];
        end
        res[3] = mul_unit(fa, UNIT - ba);
      end
      OP_ATOP: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = (fc[i] * fa + bc[i] * (UNIT - fa) + UNIT / 2) / UNIT;
        end
        res[3] = ba;
      end
      OP_PLUS: begin
        den = fa + ba;
        for (int i = 0; i < 3; i++) begin
          res[i] = div_round(fc[i] * fa + bc[i] * ba, den);
        end
        res[3] = den;
      end
      OP_THROUGH: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = (fc[i] * (UNIT - ba) * UNIT + fc[i] * bc[i] * ba
                    + (UNIT * UNIT) / 2) / (UNIT * UNIT);
        end
        res[3] = fa;
      end
      default: begin
      end
    endcase
    r.out_red   = field_t'(clamp_unit(res[0]));
    r.out_green = field_t'(clamp_unit(res[1]));
    r.out_blue  = field_t'(clamp_unit(res[2]));
    r.out_alpha = field_t'(clamp_unit(res[3]));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pdc_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_out <= n_out + 1;
        if (expected_pixels.size() == 0) begin
          errs <= errs + 1;
          if (reported < REPORT_MAX) begin
            $display("[%0t] pixel %0d arrived with nothing expected: rgba %0d %0d %0d %0d",
                     $time, n_out, out_data.out_red, out_data.out_green,
                     out_data.out_blue, out_data.out_alpha);
          end
          reported++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.out_red !== out_data.out_red || want.out_green !== out_data.out_green
              || want.out_blue !== out_data.out_blue
              || want.out_alpha !== out_data.out_alpha) begin
            errs <= errs + 1;
            if (reported < REPORT_MAX) begin
              $display("[%0t] pixel %0d mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $time, n_out, want.out_red, want.out_green, want.out_blue,
                       want.out_alpha, out_data.out_red, out_data.out_green,
                       out_data.out_blue, out_data.out_alpha);
            end
            reported++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back(blend_pixel(in_data));
        n_in <= n_in + 1;
      end
      n_wait <= expected_pixels.size();
    end
  end

endmodule

[sim/tb_porter_duff_compositor_core.sv]
// ----------------------------------------------------------------------------
// tb_porter_duff_compositor_core
// Stimulus and verdict for the Porter-Duff compositor core.
// ----------------------------------------------------------------------------
// Sends a directed set of corner pixels for every operator and the spare
// opcodes, then random pixel pairs in four flow-control phases: free flow,
// sender gaps, receiver stalls, and both. A side checker predicts and
// compares every composited pixel; this module only drives and judges.
`timescale 1ns / 1ps

module tb_porter_duff_compositor_core import pdc_pkg::*;;

  localparam int RANDOM_BEATS = 1650;
  localparam int PHASES       = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RESET_CYCLES = 11;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pdc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pdc_out_t out_data;

  int err_count;
  int beats_in;
  int beats_out;
  int pixels_waiting;

  pdc_in_t beat_q [$];
  int beats_queued   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_cnt      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  porter_duff_compositor_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pdc_blend_checker blend_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .err_count      (err_count),
    .beats_in       (beats_in),
    .beats_out      (beats_out),
    .pixels_waiting (pixels_waiting)
  );

  function automatic field_t pick_channel();
    int sel;
    sel = $urandom_range(19, 0);
    if (sel == 0) begin
      return '0;
    end
    if (sel == 1) begin
      return '1;
    end
    if (sel == 2) begin
      return field_t'(1);
    end
    if (sel == 3) begin
      return field_t'(254);
    end
    return field_t'($urandom_range(255, 0));
  endfunction

  function automatic logic [2:0] pick_opcode();
    int sel;
    sel = $urandom_range(19, 0);
    if (sel == 0) begin
      return OP_SPARE_LO;
    end
    if (sel == 1) begin
      return OP_SPARE_HI;
    end
    return 3'($urandom_range(int'(OP_THROUGH), int'(OP_OVER)));
  endfunction

  task automatic queue_beat(input logic [2:0] op,
                            input field_t fr, input field_t fg,
                            input field_t fb, input field_t fa,
                            input field_t br, input field_t bgr,
                            input field_t bb, input field_t ba);
    pdc_in_t px;
    px.opcode   = op;
    px.fg_red   = fr;
    px.fg_green = fg;
    px.fg_blue  = fb;
    px.fg_alpha = fa;
    px.bg_red   = br;
    px.bg_green = bgr;
    px.bg_blue  = bb;
    px.bg_alpha = ba;
    beat_q.push_back(px);
    beats_queued++;
  endtask

  // hold valid and payload until the beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (beat_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_data  <= beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d of %0d pixels returned",
             cycle_cnt, beats_out, beats_queued);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_beat(OP_OVER, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_beat(OP_PLUS, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_beat(OP_OVER, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_beat(OP_OVER, 8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd255);
    queue_beat(OP_OVER, 8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30, 8'd128);
    queue_beat(OP_IN, 8'd255, 8'd0, 8'd128, 8'd255, 8'd1, 8'd2, 8'd3, 8'd0);
    queue_beat(OP_IN, 8'd17, 8'd34, 8'd51, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255);
    queue_beat(OP_OUT, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_OUT, 8'd9, 8'd8, 8'd7, 8'd200, 8'd0, 8'd0, 8'd0, 8'd255);
    queue_beat(OP_ATOP, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd77);
    queue_beat(OP_ATOP, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    queue_beat(OP_PLUS, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_beat(OP_PLUS, 8'd200, 8'd100, 8'd50, 8'd200, 8'd10, 8'd20, 8'd30, 8'd100);
    queue_beat(OP_THROUGH, 8'd255, 8'd128, 8'd1, 8'd90, 8'd255, 8'd0, 8'd128, 8'd255);
    queue_beat(OP_THROUGH, 8'd255, 8'd128, 8'd1, 8'd90, 8'd255, 8'd0, 8'd128, 8'd0);
    queue_beat(OP_SPARE_LO, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_beat(OP_SPARE_HI, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    for (int op = 0; op < 8; op++) begin
      queue_beat(3'(op), '0, '0, '0, '0, '0, '0, '0, '0);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      for (int n = 0; n < RANDOM_BEATS / PHASES; n++) begin
        queue_beat(pick_opcode(), pick_channel(), pick_channel(), pick_channel(),
                   pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                   pick_channel());
      end
      while (beats_in != beats_queued) @(negedge clk);
    end

    while (pixels_waiting != 0 || beats_out != beats_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Composited %0d pixel pairs over all operators and spare opcodes, %0d results",
             beats_in, beats_out);
    $display("checked under free flow, sender gaps, receiver stalls and both; %0d mismatches",
             err_count);
    if (err_count == 0 && pixels_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pdc_pkg.sv
hdl/pdc_front.sv
hdl/pdc_div.sv
hdl/porter_duff_compositor_core.sv
sim/pdc_blend_checker.sv
sim/tb_porter_duff_compositor_core.sv
